/* rtl/assert_macros.svh */
// Assertion macros used by the top RTL file of the padded integer text block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/itpt_pkg.sv */
// Shared types, constants and a helper function of the padded integer text block.
package itpt_pkg;

  // Field and datapath widths.
  localparam int unsigned MagW      = 64;
  localparam int unsigned DecDigits = 20;
  localparam int unsigned BcdW      = 4 * DecDigits;
  localparam int unsigned PosW      = 7;
  localparam int unsigned MaxField  = 62;

  // Radix mode codes of the input item.
  localparam logic [2:0] RadixDec   = 3'd0;
  localparam logic [2:0] RadixOct   = 3'd1;
  localparam logic [2:0] RadixHexLo = 3'd2;
  localparam logic [2:0] RadixHexUp = 3'd3;
  localparam logic [2:0] RadixChar  = 3'd4;

  // Sign style codes for positive values.
  localparam logic [1:0] SignNone  = 2'd0;
  localparam logic [1:0] SignBlank = 2'd1;
  localparam logic [1:0] SignPlus  = 2'd2;

  // Character codes.
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChUpA   = 8'h41;

  // Number base of a conversion.
  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_OCT = 2'd1,
    BASE_HEX = 2'd2
  } base_e;

  // Decoded format of one conversion, held for the whole item.
  typedef struct packed {
    base_e       base;
    logic        upper;
    logic        alt;
    logic        zpad;
    logic        ladj;
    logic        sgn;
    logic        neg;
    logic [1:0]  style;
    logic [5:0]  width;
    logic        has_prec;
    logic [5:0]  prec;
    logic        mag_zero;
    logic        char_mode;
    logic [7:0]  char_byte;
  } fmt_t;

  // Maps a digit value to its character.
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] ch;
    if (d < 4'd10) begin
      ch = ChZero + {4'd0, d};
    end else begin
      ch = (upper ? ChUpA : ChLowA) + {4'd0, d} - 8'd10;
    end
    return ch;
  endfunction

endpackage

/* rtl/itpt_digits.sv */
// Digit extraction unit: binary-to-BCD shifter and digit store.
module itpt_digits import itpt_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 22,
  localparam int unsigned LenW = $clog2(MAX_DIGITS + 1),
  localparam int unsigned IdxW = $clog2(MAX_DIGITS)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [MagW-1:0] mag_i,
  input  base_e           base_i,
  input  logic            upper_i,
  output logic            busy_o,
  output logic [LenW-1:0] len_o,
  input  logic [IdxW-1:0] rd_idx_i,
  output logic [7:0]      rd_data_o
);

  typedef enum logic [2:0] {
    DIG_IDLE    = 3'b001,
    DIG_DABBLE  = 3'b010,
    DIG_EXTRACT = 3'b100
  } dig_state_e;

  dig_state_e      state_q, state_d;
  logic [5:0]      step_q, step_d;
  logic [LenW-1:0] len_q, len_d;
  logic [MagW-1:0] bin_q, bin_d;
  logic [BcdW-1:0] work_q, work_d;
  base_e           base_q;
  logic            upper_q;
  logic [BcdW-1:0] work_adj;
  logic [BcdW-1:0] work_shr;
  logic [3:0]      digit_val;
  logic            store_we;
  logic [7:0]      store_q [MAX_DIGITS];
  logic [7:0]      rd_data_q;

  // Add-three correction on every BCD digit before the shift.
  always_comb begin
    for (int g = 0; g < DecDigits; g++) begin
      work_adj[4*g +: 4] = (work_q[4*g +: 4] >= 4'd5) ? work_q[4*g +: 4] + 4'd3
                                                      : work_q[4*g +: 4];
    end
  end

  // Low digit of the work register and the register shifted past it.
  always_comb begin
    if (base_q == BASE_OCT) begin
      digit_val = {1'b0, work_q[2:0]};
      work_shr  = work_q >> 3;
    end else begin
      digit_val = work_q[3:0];
      work_shr  = work_q >> 4;
    end
  end

  // Sequencer for the shifter and the extraction loop.
  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    len_d    = len_q;
    bin_d    = bin_q;
    work_d   = work_q;
    store_we = 1'b0;
    unique case (state_q)
      DIG_IDLE: begin
        if (start_i) begin
          len_d  = '0;
          step_d = '0;
          if (base_i == BASE_DEC) begin
            bin_d   = mag_i;
            work_d  = '0;
            state_d = DIG_DABBLE;
          end else begin
            work_d  = BcdW'(mag_i);
            state_d = DIG_EXTRACT;
          end
        end
      end
      DIG_DABBLE: begin
        work_d = {work_adj[BcdW-2:0], bin_q[MagW-1]};
        bin_d  = {bin_q[MagW-2:0], 1'b0};
        step_d = step_q + 6'd1;
        if (step_q == 6'd63) begin
          state_d = DIG_EXTRACT;
        end
      end
      DIG_EXTRACT: begin
        store_we = 1'b1;
        work_d   = work_shr;
        len_d    = len_q + LenW'(1);
        if ((work_shr == '0) || (len_q == LenW'(MAX_DIGITS - 1))) begin
          state_d = DIG_IDLE;
        end
      end
      default: state_d = DIG_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIG_IDLE;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    bin_q  <= bin_d;
    work_q <= work_d;
    if (start_i && (state_q == DIG_IDLE)) begin
      base_q  <= base_i;
      upper_q <= upper_i;
    end
  end

  // Digit store, least significant digit first, with a registered read port.
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[len_q[IdxW-1:0]] <= digit_char(digit_val, upper_q);
    end
    rd_data_q <= store_q[rd_idx_i];
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = (state_q != DIG_IDLE);
  assign len_o     = len_q;

endmodule

/* rtl/itpt_emit.sv */
// Field layout and character serializer with the output register.
module itpt_emit import itpt_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 22,
  localparam int unsigned LenW = $clog2(MAX_DIGITS + 1),
  localparam int unsigned IdxW = $clog2(MAX_DIGITS)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  fmt_t            fmt_i,
  input  logic [LenW-1:0] len_i,
  output logic            busy_o,
  output logic [IdxW-1:0] rd_idx_o,
  input  logic [7:0]      rd_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      char_out_o,
  output logic            last_char_o
);

  typedef enum logic [3:0] {
    EM_IDLE   = 4'b0001,
    EM_LAYOUT = 4'b0010,
    EM_BOUNDS = 4'b0100,
    EM_RUN    = 4'b1000
  } em_state_e;

  em_state_e       state_q, state_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      char_q;
  logic            last_q;

  logic [PosW-1:0] len7, prec7, width7;
  logic [PosW-1:0] lz0, body, pad;
  logic [PosW-1:0] leftsp, rightsp, lz;
  logic [1:0]      prelen;
  logic [7:0]      pre0, pre1;

  logic [PosW-1:0] leftsp_q, rightsp_q, lz_q;
  logic [1:0]      prelen_q;
  logic [7:0]      pre0_q, pre1_q;

  logic [PosW-1:0] b2, b3, b4, total;
  logic [PosW-1:0] b1_q, b2_q, b3_q, b4_q, last_pos_q;

  logic            load;
  logic [PosW-1:0] dig_k, dig_idx;
  logic [7:0]      next_char;

  assign len7   = PosW'(len_i);
  assign prec7  = PosW'(fmt_i.prec);
  assign width7 = PosW'(fmt_i.width);

  // Precision zeros, prefix and padding of the field.
  always_comb begin
    lz0    = (fmt_i.has_prec && (prec7 > len7)) ? prec7 - len7 : '0;
    prelen = 2'd0;
    pre0   = ChZero;
    pre1   = ChZero;
    if (fmt_i.base == BASE_OCT) begin
      if (fmt_i.alt && !fmt_i.mag_zero && (lz0 == '0)) begin
        prelen = 2'd1;
      end
    end else if (fmt_i.base == BASE_HEX) begin
      if (fmt_i.alt && !fmt_i.mag_zero) begin
        prelen = 2'd2;
        pre1   = fmt_i.upper ? ChUpX : ChLowX;
      end
    end else if (fmt_i.sgn) begin
      if (fmt_i.neg) begin
        prelen = 2'd1;
        pre0   = ChMinus;
      end else if (fmt_i.style[1]) begin
        prelen = 2'd1;
        pre0   = ChPlus;
      end else if (fmt_i.style == SignBlank) begin
        prelen = 2'd1;
        pre0   = ChSpace;
      end
    end
    body    = PosW'(prelen) + lz0 + len7;
    pad     = (width7 > body) ? width7 - body : '0;
    leftsp  = fmt_i.ladj ? '0 : pad;
    rightsp = fmt_i.ladj ? pad : '0;
    lz      = lz0;
    if (fmt_i.zpad && !fmt_i.has_prec) begin
      lz     = lz0 + leftsp;
      leftsp = '0;
    end
  end

  // Section boundaries as character positions.
  assign b2    = leftsp_q + PosW'(prelen_q);
  assign b3    = b2 + lz_q;
  assign b4    = b3 + len7;
  assign total = b4 + rightsp_q;

  // Store address of the digit at the next position; the registered read
  // delivers it in step with the position register.
  assign dig_k    = pos_d - b3;
  assign dig_idx  = len7 - PosW'(1) - dig_k;
  assign rd_idx_o = dig_idx[IdxW-1:0];

  // Character at the current position.
  always_comb begin
    if (fmt_i.char_mode) begin
      next_char = fmt_i.char_byte;
    end else if (pos_q < b1_q) begin
      next_char = ChSpace;
    end else if (pos_q < b2_q) begin
      next_char = (pos_q == b1_q) ? pre0_q : pre1_q;
    end else if (pos_q < b3_q) begin
      next_char = ChZero;
    end else if (pos_q < b4_q) begin
      next_char = rd_data_i;
    end else begin
      next_char = ChSpace;
    end
  end

  assign load = (state_q == EM_RUN) && (!out_valid_q || out_ready_i);

  // Serializer sequencer.
  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    unique case (state_q)
      EM_IDLE: begin
        if (start_i) begin
          pos_d   = '0;
          state_d = EM_LAYOUT;
        end
      end
      EM_LAYOUT: state_d = EM_BOUNDS;
      EM_BOUNDS: state_d = EM_RUN;
      EM_RUN: begin
        if (load) begin
          pos_d = pos_q + PosW'(1);
          if (pos_q == last_pos_q) begin
            state_d = EM_IDLE;
          end
        end
      end
      default: state_d = EM_IDLE;
    endcase
  end

  // Output beat valid: set on a load, cleared when the beat is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= EM_IDLE;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Layout and output payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == EM_LAYOUT) begin
      leftsp_q  <= leftsp;
      rightsp_q <= rightsp;
      lz_q      <= lz;
      prelen_q  <= prelen;
      pre0_q    <= pre0;
      pre1_q    <= pre1;
    end
    if (state_q == EM_BOUNDS) begin
      b1_q       <= leftsp_q;
      b2_q       <= b2;
      b3_q       <= b3;
      b4_q       <= b4;
      last_pos_q <= fmt_i.char_mode ? '0 : total - PosW'(1);
    end
    if (load) begin
      char_q <= next_char;
      last_q <= (pos_q == last_pos_q);
    end
  end

  assign busy_o      = (state_q != EM_IDLE);
  assign out_valid_o = out_valid_q;
  assign char_out_o  = char_q;
  assign last_char_o = last_q;

endmodule

/* rtl/integer_to_padded_text.sv */
// Decimal items first pass through the binary-to-BCD shifter; numeric items then pass
// through the extraction loop (1 to 22 digits), and every item that prints goes through
// the layout and bounds states and the output register (up to 64 characters).
// The input stays closed while an item is in progress, including any output stalls;
// it reopens after the serializer and then the item sequencer return to idle.
// Reset clears the sequencers and the output valid; the digit store is not reset.
`include "assert_macros.svh"

module integer_to_padded_text import itpt_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 22
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [63:0]       magnitude_i,
  input  logic              is_negative_i,
  input  logic              is_signed_i,
  input  logic [2:0]        radix_mode_i,
  input  logic              alternate_form_i,
  input  logic              zero_pad_i,
  input  logic              left_adjust_i,
  input  logic [1:0]        sign_style_i,
  input  logic [5:0]        field_width_i,
  input  logic signed [6:0] min_digits_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        char_out_o,
  output logic              last_char_o
);

  localparam int unsigned LenW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned IdxW = $clog2(MAX_DIGITS);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DIGITS = 3'b010,
    ST_EMIT   = 3'b100
  } top_state_e;

  top_state_e      state_q, state_d;
  fmt_t            fmt_q, fmt_d;
  logic            in_fire;
  logic            skip;
  logic            dig_start, emit_start;
  logic            dig_busy, emit_busy;
  logic [LenW-1:0] dig_len;
  logic [IdxW-1:0] rd_idx;
  logic [7:0]      rd_data;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Decode and saturate the format of the incoming item.
  always_comb begin
    fmt_d.upper     = (radix_mode_i == RadixHexUp);
    fmt_d.char_mode = (radix_mode_i == RadixChar);
    unique case (radix_mode_i) inside
      RadixOct:               fmt_d.base = BASE_OCT;
      RadixHexLo, RadixHexUp: fmt_d.base = BASE_HEX;
      default:                fmt_d.base = BASE_DEC;
    endcase
    fmt_d.alt       = alternate_form_i;
    fmt_d.zpad      = zero_pad_i;
    fmt_d.ladj      = left_adjust_i;
    fmt_d.sgn       = is_signed_i;
    fmt_d.neg       = is_negative_i;
    fmt_d.style     = sign_style_i;
    fmt_d.width     = (field_width_i > 6'(MaxField)) ? 6'(MaxField) : field_width_i;
    fmt_d.has_prec  = !min_digits_i[6];
    fmt_d.prec      = !fmt_d.has_prec ? 6'd0
                    : (min_digits_i[5:0] > 6'(MaxField)) ? 6'(MaxField)
                    : min_digits_i[5:0];
    fmt_d.mag_zero  = (magnitude_i == '0);
    fmt_d.char_byte = magnitude_i[7:0];
  end

  // Zero printed with a precision of zero yields no characters.
  assign skip = fmt_d.has_prec && (fmt_d.prec == 6'd0) && fmt_d.mag_zero;

  // Item sequencer: digits first (not in character mode), then layout and serialization.
  always_comb begin
    state_d    = state_q;
    dig_start  = 1'b0;
    emit_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (fmt_d.char_mode) begin
            emit_start = 1'b1;
            state_d    = ST_EMIT;
          end else if (!skip) begin
            dig_start = 1'b1;
            state_d   = ST_DIGITS;
          end
        end
      end
      ST_DIGITS: begin
        if (!dig_busy) begin
          emit_start = 1'b1;
          state_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!emit_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Format of the current item.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      fmt_q <= fmt_d;
    end
  end

  itpt_digits #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_digits (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (dig_start),
    .mag_i     (magnitude_i),
    .base_i    (fmt_d.base),
    .upper_i   (fmt_d.upper),
    .busy_o    (dig_busy),
    .len_o     (dig_len),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_data)
  );

  itpt_emit #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (emit_start),
    .fmt_i       (fmt_q),
    .len_i       (dig_len),
    .busy_o      (emit_busy),
    .rd_idx_o    (rd_idx),
    .rd_data_i   (rd_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .char_out_o  (char_out_o),
    .last_char_o (last_char_o)
  );

  // The input side opens only when both units are idle.
  `ASSERT_IMPLIES(a_ready_idle, in_ready_o, !dig_busy && !emit_busy, "ready while a unit is busy")
  // Digit extraction and serialization never overlap.
  `ASSERT_ALWAYS(a_units_exclusive, !(dig_busy && emit_busy), "digit and emit units both busy")
  // The serializer finishes exactly when it loads the final beat.
  `ASSERT_IMPLIES(a_last_on_finish, $fell(emit_busy), out_valid_o && last_char_o, "finish without last beat")

endmodule

/* tb/sv/integer_to_padded_text_tb.sv */
// Self-checking testbench of the printf-style padded integer text block.
`timescale 1ns / 100ps

module integer_to_padded_text_tb;
  import itpt_pkg::*;

  // Precision code for none given, and run sizes.
  localparam logic signed [6:0] PrecNone = -7'sd1;
  localparam int DigitsMax = 22;
  localparam int RandomItems = 145;
  localparam int DrainCycles = 200;
  localparam int CycleLimit = 1000000;
  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

  // One conversion request as it travels on the input channel.
  typedef struct {
    logic [63:0] mag;
    logic neg;
    logic sgn;
    logic [2:0] radix;
    logic alt;
    logic zpad;
    logic ladj;
    logic [1:0] style;
    logic [5:0] width;
    logic signed [6:0] prec;
  } conv_req_t;

  // One character beat of the output channel.
  typedef struct packed {
    logic [7:0] ch;
    logic last;
  } text_beat_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [63:0] magnitude_i = '0;
  logic is_negative_i = 1'b0;
  logic is_signed_i = 1'b0;
  logic [2:0] radix_mode_i = RadixDec;
  logic alternate_form_i = 1'b0;
  logic zero_pad_i = 1'b0;
  logic left_adjust_i = 1'b0;
  logic [1:0] sign_style_i = SignNone;
  logic [5:0] field_width_i = '0;
  logic signed [6:0] min_digits_i = PrecNone;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [7:0] char_out_o;
  logic last_char_o;

  conv_req_t pending_convs[$];
  text_beat_t expected_text[$];
  conv_req_t cur_req;
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  int in_gap = 0;
  int out_wait = 0;
  int in_burst = 0;
  int out_burst = 0;
  int cycle_count = 0;
  int mismatch_count = 0;

  integer_to_padded_text dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .magnitude_i     (magnitude_i),
    .is_negative_i   (is_negative_i),
    .is_signed_i     (is_signed_i),
    .radix_mode_i    (radix_mode_i),
    .alternate_form_i(alternate_form_i),
    .zero_pad_i      (zero_pad_i),
    .left_adjust_i   (left_adjust_i),
    .sign_style_i    (sign_style_i),
    .field_width_i   (field_width_i),
    .min_digits_i    (min_digits_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .char_out_o      (char_out_o),
    .last_char_o     (last_char_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Wait of one side before its next beat: mostly drawn at random, with bursts of no wait.
  function automatic int draw_wait(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(8, 24);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  // Queues one conversion request for the driver.
  task automatic add_conv(input logic [63:0] mag, input logic neg, input logic sgn,
                          input logic [2:0] radix, input logic alt, input logic zpad,
                          input logic ladj, input logic [1:0] style,
                          input logic [5:0] width, input logic signed [6:0] prec);
    conv_req_t r;
    r.mag = mag;
    r.neg = neg;
    r.sgn = sgn;
    r.radix = radix;
    r.alt = alt;
    r.zpad = zpad;
    r.ladj = ladj;
    r.style = style;
    r.width = width;
    r.prec = prec;
    pending_convs.push_back(r);
  endtask

  // Builds the text that one request must produce and queues it character by character.
  function automatic void predict_text(input conv_req_t r);
    logic [7:0] digs[DigitsMax];
    logic [7:0] pfx[2];
    logic [7:0] text_q[$];
    logic [63:0] rest;
    logic [63:0] base;
    logic [3:0] d;
    logic has_prec;
    logic upper;
    text_beat_t beat;
    int prec, wid, len, plen, lzero, lsp, rsp, body;

    wid = (r.width > MaxField) ? MaxField : r.width;
    has_prec = !r.prec[6];
    prec = has_prec ? int'(r.prec[5:0]) : 0;
    if (prec > MaxField) prec = MaxField;

    // Character mode sends the low byte alone.
    if (r.radix == RadixChar) begin
      beat.ch = r.mag[7:0];
      beat.last = 1'b1;
      expected_text.push_back(beat);
      return;
    end
    // Zero with an explicit precision of zero prints nothing at all.
    if (has_prec && prec == 0 && r.mag == 0) return;

    case (r.radix) inside
      RadixOct: base = 64'd8;
      RadixHexLo, RadixHexUp: base = 64'd16;
      default: base = 64'd10;
    endcase
    upper = (r.radix == RadixHexUp);

    // Digits, least significant first.
    len = 0;
    rest = r.mag;
    if (rest == 0) begin
      digs[0] = ChZero;
      len = 1;
    end else begin
      while (rest != 0 && len < DigitsMax) begin
        d = 4'(rest % base);
        digs[len] = (d < 4'd10) ? ChZero + 8'(d) : (upper ? ChUpA : ChLowA) + 8'(d) - 8'd10;
        len++;
        rest = rest / base;
      end
    end

    lzero = (has_prec && prec > len) ? prec - len : 0;

    // Alternate form prefix; octal drops its zero when the precision already adds one.
    plen = 0;
    if (base != 10 && r.alt && r.mag != 0) begin
      if (base == 8) begin
        if (lzero == 0) begin
          pfx[0] = ChZero;
          plen = 1;
        end
      end else begin
        pfx[0] = ChZero;
        pfx[1] = upper ? ChUpX : ChLowX;
        plen = 2;
      end
    end
    // Sign prefix of signed decimal; the top bit of the style selects plus.
    if (base == 10 && r.sgn) begin
      if (r.neg) begin
        pfx[plen] = ChMinus;
        plen++;
      end else if (r.style[1]) begin
        pfx[plen] = ChPlus;
        plen++;
      end else if (r.style == SignBlank) begin
        pfx[plen] = ChSpace;
        plen++;
      end
    end

    // Padding to the field width.
    lsp = 0;
    rsp = 0;
    body = plen + lzero + len;
    if (wid > body) begin
      if (r.ladj) rsp = wid - body;
      else lsp = wid - body;
    end
    if (r.zpad && !has_prec) begin
      lzero += lsp;
      lsp = 0;
    end

    repeat (lsp) text_q.push_back(ChSpace);
    for (int i = 0; i < plen; i++) text_q.push_back(pfx[i]);
    repeat (lzero) text_q.push_back(ChZero);
    for (int i = len - 1; i >= 0; i--) text_q.push_back(digs[i]);
    repeat (rsp) text_q.push_back(ChSpace);

    for (int i = 0; i < text_q.size(); i++) begin
      beat.ch = text_q[i];
      beat.last = (i == text_q.size() - 1);
      expected_text.push_back(beat);
    end
  endfunction

  // Input driver: holds each beat until it is taken, then waits its drawn gap.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) in_gap = draw_wait(in_burst);
      if (in_valid_i && !in_taken) begin
        // Beat still waiting for ready.
      end else if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap--;
      end else if (pending_convs.size() > 0) begin
        cur_req = pending_convs.pop_front();
        magnitude_i <= cur_req.mag;
        is_negative_i <= cur_req.neg;
        is_signed_i <= cur_req.sgn;
        radix_mode_i <= cur_req.radix;
        alternate_form_i <= cur_req.alt;
        zero_pad_i <= cur_req.zpad;
        left_adjust_i <= cur_req.ladj;
        sign_style_i <= cur_req.style;
        field_width_i <= cur_req.width;
        min_digits_i <= cur_req.prec;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
      in_taken = 1'b0;
    end
  end

  // Output ready: drops for a drawn number of cycles after each beat.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) out_wait = draw_wait(out_burst);
      if (out_wait > 0) begin
        out_ready_i <= 1'b0;
        out_wait--;
      end else begin
        out_ready_i <= 1'b1;
      end
      out_taken = 1'b0;
    end
  end

  // Monitor: predicts on each input beat and checks each output beat.
  always @(posedge clk_i) begin : monitor
    text_beat_t want;
    if (rst_ni) begin
      cycle_count++;
      if (in_valid_i && in_ready_o) begin
        predict_text(cur_req);
        in_taken = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        out_taken = 1'b1;
        if (expected_text.size() == 0) begin
          $error("char_out: no character expected, actual %h", char_out_o);
          mismatch_count++;
        end else begin
          want = expected_text.pop_front();
          if (char_out_o !== want.ch) begin
            $error("char_out: expected %h, actual %h", want.ch, char_out_o);
            mismatch_count++;
          end
          if (last_char_o !== want.last) begin
            $error("last_char: expected %b, actual %b", want.last, last_char_o);
            mismatch_count++;
          end
        end
      end
      if (cycle_count >= CycleLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin : stimulus
    logic [63:0] mag;
    logic [5:0] width;
    logic signed [6:0] prec;
    logic [2:0] radix;

    in_gap = draw_wait(in_burst);

    // Directed part: field extremes, every radix and the special cases.
    add_conv(64'd0, 1'b0, 1'b0, RadixDec, 1'b0, 1'b0, 1'b0, SignNone, 6'd0, PrecNone);
    add_conv(AllOnes, 1'b0, 1'b0, RadixDec, 1'b0, 1'b0, 1'b0, SignNone, 6'd0, PrecNone);
    add_conv(64'd1234, 1'b1, 1'b1, RadixDec, 1'b0, 1'b1, 1'b0, SignNone, 6'd10, PrecNone);
    add_conv(64'd77, 1'b0, 1'b1, RadixDec, 1'b0, 1'b0, 1'b1, SignBlank, 6'd8, PrecNone);
    add_conv(64'd42, 1'b0, 1'b1, RadixDec, 1'b0, 1'b0, 1'b0, SignPlus, 6'd0, 7'sd5);
    add_conv(64'd0, 1'b0, 1'b1, RadixDec, 1'b0, 1'b0, 1'b0, 2'd3, 6'd4, PrecNone);
    add_conv(64'd0, 1'b1, 1'b1, RadixDec, 1'b0, 1'b0, 1'b0, SignNone, 6'd0, PrecNone);
    add_conv(64'd8, 1'b0, 1'b0, RadixOct, 1'b1, 1'b0, 1'b0, SignNone, 6'd0, PrecNone);
    add_conv(64'd8, 1'b0, 1'b0, RadixOct, 1'b1, 1'b0, 1'b0, SignNone, 6'd0, 7'sd4);
    add_conv(64'd8, 1'b0, 1'b0, RadixOct, 1'b1, 1'b1, 1'b0, SignNone, 6'd6, PrecNone);
    add_conv(64'hDEAD_BEEF, 1'b0, 1'b0, RadixHexLo, 1'b1, 1'b1, 1'b0, SignNone, 6'd14,
             PrecNone);
    add_conv(64'hCAFE, 1'b0, 1'b0, RadixHexUp, 1'b1, 1'b0, 1'b1, SignNone, 6'd12, PrecNone);
    add_conv(64'd0, 1'b0, 1'b0, RadixHexLo, 1'b1, 1'b0, 1'b0, SignNone, 6'd0, PrecNone);
    add_conv(64'd0, 1'b0, 1'b1, RadixDec, 1'b0, 1'b0, 1'b0, SignPlus, 6'd0, 7'sd0);
    add_conv(64'd0, 1'b0, 1'b0, RadixHexUp, 1'b1, 1'b0, 1'b0, SignNone, 6'd10, 7'sd0);
    add_conv(64'hFFFF_FFFF_FFFF_FF41, 1'b1, 1'b1, RadixChar, 1'b1, 1'b1, 1'b1, SignPlus,
             6'd20, 7'sd9);
    add_conv(64'd5, 1'b0, 1'b0, RadixDec, 1'b0, 1'b1, 1'b0, SignNone, 6'd10, 7'sd3);
    add_conv(64'd1, 1'b0, 1'b0, RadixHexLo, 1'b1, 1'b0, 1'b0, SignNone, 6'd63, 7'sd63);
    add_conv(64'd99, 1'b0, 1'b0, RadixDec, 1'b0, 1'b1, 1'b0, SignNone, 6'd20, -7'sd64);
    add_conv(64'd31, 1'b0, 1'b0, 3'd7, 1'b1, 1'b0, 1'b0, SignNone, 6'd0, PrecNone);
    add_conv(64'd17, 1'b1, 1'b1, 3'd5, 1'b0, 1'b0, 1'b0, SignNone, 6'd0, PrecNone);
    add_conv(AllOnes, 1'b0, 1'b0, RadixOct, 1'b1, 1'b0, 1'b0, SignNone, 6'd0, PrecNone);
    add_conv(AllOnes, 1'b1, 1'b1, RadixDec, 1'b0, 1'b0, 1'b0, SignNone, 6'd62, 7'sd62);
    add_conv(64'd7, 1'b0, 1'b0, RadixDec, 1'b0, 1'b1, 1'b1, SignNone, 6'd10, PrecNone);
    add_conv(AllOnes, 1'b0, 1'b0, RadixHexUp, 1'b0, 1'b0, 1'b0, SignNone, 6'd0, PrecNone);

    // Random part: mixed magnitude sizes, mostly modest widths and precisions.
    repeat (RandomItems) begin
      case ($urandom_range(0, 5))
        0: mag = 64'd0;
        1: mag = $urandom_range(0, 255);
        2: mag = $urandom;
        3, 4: mag = {$urandom, $urandom} >> $urandom_range(0, 63);
        default: mag = {$urandom, $urandom};
      endcase
      radix = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, 4));
      width = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(40, 63))
                                          : 6'($urandom_range(0, 16));
      case ($urandom_range(0, 9))
        0, 1, 2, 3: prec = PrecNone;
        4: prec = 7'($urandom_range(64, 126));
        5: prec = 7'sd0;
        6, 7, 8: prec = 7'($urandom_range(1, 24));
        default: prec = 7'($urandom_range(40, 63));
      endcase
      add_conv(mag, 1'($urandom), 1'($urandom), radix, 1'($urandom), 1'($urandom),
               1'($urandom), 2'($urandom), width, prec);
    end

    // Reset once, then release at a falling edge.
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Drain: every request taken, every character seen, then a quiet stretch.
    while (pending_convs.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_text.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_text.size() != 0) begin
      $error("char_out: %0d characters never arrived", expected_text.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
